// ===== rtl/wcmd_pkg.sv =====
package wcmd_pkg;

   localparam int DirWidth   = 12;
   localparam int TrigWidth  = 16;
   localparam int SumWidth   = 32;
   localparam int AngWidth   = 24;
   localparam int CordSteps  = 16;
   localparam int FullTurn   = 3600;
   localparam int HalfTurn   = 1800;
   localparam int QuarterTurn = 900;
   localparam logic [31:0] CordStart = 32'd652032874;

   localparam int RotWidth  = 32;
   localparam int VecWidth  = 52;
   localparam int StepBits  = 4;

   typedef logic [DirWidth-1:0] dir_type;
   typedef logic signed [TrigWidth-1:0] trig_type;
   typedef logic signed [SumWidth-1:0] sum_type;
   typedef logic signed [AngWidth-1:0] ang_type;

   function automatic ang_type atan_units(input logic [StepBits-1:0] i);
      ang_type r;
      case (i)
         4'd0:  r = 24'sd450000;
         4'd1:  r = 24'sd265651;
         4'd2:  r = 24'sd140362;
         4'd3:  r = 24'sd71250;
         4'd4:  r = 24'sd35763;
         4'd5:  r = 24'sd17899;
         4'd6:  r = 24'sd8952;
         4'd7:  r = 24'sd4476;
         4'd8:  r = 24'sd2238;
         4'd9:  r = 24'sd1119;
         4'd10: r = 24'sd560;
         4'd11: r = 24'sd280;
         4'd12: r = 24'sd140;
         4'd13: r = 24'sd70;
         4'd14: r = 24'sd35;
         default: r = 24'sd17;
      endcase
      return r;
   endfunction

   // round half up to Q1.15 with saturation
   function automatic trig_type to_q15(input logic signed [RotWidth-1:0] v);
      logic signed [RotWidth:0] t;
      logic signed [RotWidth-15:0] r;
      begin
         t = {v[RotWidth-1], v} + (RotWidth+1)'(16384);
         r = t[RotWidth:15];
         if (r > 32767) return 16'sh7fff;
         else if (r < -32768) return 16'sh8000;
         else return r[15:0];
      end
   endfunction

endpackage

// ===== rtl/windowed_circular_mean_direction_unit.sv =====
// Processing of an accepted item, N samples in the window: a summing pass that, per
//   sample, does one memory read and runs the 16-step sine/cosine CORDIC, then the
//   bearing CORDIC and divide, then the deviation pass (one read per sample) and
//   the output load, before rsp_tvalid.
// One item at a time: a new item is taken only once the last one is through.
//   A result still waiting in the output register holds off the next one.
// Reset (synchronous): pointer and fill count cleared, window 360.
//   History memory is not cleared; only written entries are ever read.
module windowed_circular_mean_direction_unit #(
   parameter int DEPTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] direction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [11:0] mean_direction, [23:12] port_range,
                                    // [35:24] starboard_range, [47:36] samples_used
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [11:0] window_len
);
   import wcmd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RDA   = 7'b0000010,   // issue read for summing pass
      S_TRIG  = 7'b0000100,   // wait for CORDIC, accumulate
      S_BEAR  = 7'b0001000,
      S_RDB   = 7'b0010000,   // deviation pass reads
      S_LAST  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   dir_type mem [DEPTH];
   dir_type rd_ff;
   logic [AW-1:0] wp_ff, wp_in, ra_ff, ra_in;
   logic [CW-1:0] fill_ff, fill_in, n_ff, n_in, k_ff, k_in;
   logic [DirWidth-1:0] win_ff;
   sum_type se_ff, se_in, sn_ff, sn_in;
   logic signed [DirWidth:0] port_ff, port_in, stb_ff, stb_in;
   dir_type mean_ff, mean_in;
   logic rdv_ff, rdv_in;
   logic out_v_ff, out_v_in;
   logic [47:0] out_ff, out_in;
   logic trig_go_ff, trig_go_in, bear_go;
   logic bear_go_ff, bear_go_in;
   logic trig_done, bear_done;
   trig_type east, north;
   dir_type bmean, d_in;
   logic [CW-1:0] winc, fill_nx;
   logic signed [DirWidth+1:0] dv;
   logic signed [DirWidth:0] dvw;
   logic wr_en;

   assign d_in = (req_tdata[11:0] >= DirWidth'(FullTurn)) ?
                 req_tdata[11:0] - DirWidth'(FullTurn) : req_tdata[11:0];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign wr_en = req_tvalid && req_tready;

   // clamp window to 1..DEPTH
   always_comb begin
      if (win_ff == '0) winc = CW'(1);
      else if (CW'(win_ff) > CW'(DEPTH) || (DirWidth > CW && (win_ff >> CW) != '0))
         winc = CW'(DEPTH);
      else winc = CW'(win_ff);
   end
   assign fill_nx = (fill_ff < CW'(DEPTH)) ? fill_ff + 1'b1 : fill_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wp_ff] <= d_in;
      rd_ff <= mem[ra_ff];
   end

   wcmd_sincos u_sincos (
      .clock(clock), .reset(reset), .start(trig_go_ff), .dir(rd_ff),
      .done(trig_done), .east(east), .north(north)
   );

   wcmd_bearing u_bearing (
      .clock(clock), .reset(reset), .start(bear_go), .sum_e(se_ff), .sum_n(sn_ff),
      .done(bear_done), .mean(bmean)
   );

   // start pulse in the first bearing cycle, once the last sum is registered
   assign bear_go = bear_go_ff;

   // deviation of read sample from mean, wrapped once
   always_comb begin
      dv = $signed({2'b00, rd_ff}) - $signed({2'b00, mean_ff});
      if (dv > HalfTurn) dv = dv - (DirWidth+2)'(FullTurn);
      else if (dv < -HalfTurn) dv = dv + (DirWidth+2)'(FullTurn);
      dvw = dv[DirWidth:0];
   end

   always_comb begin
      state_in = state_ff; wp_in = wp_ff; ra_in = ra_ff; fill_in = fill_ff;
      n_in = n_ff; k_in = k_ff; se_in = se_ff; sn_in = sn_ff;
      port_in = port_ff; stb_in = stb_ff; mean_in = mean_ff; rdv_in = 1'b0;
      trig_go_in = 1'b0; bear_go_in = 1'b0; out_v_in = out_v_ff; out_in = out_ff;
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (wr_en) begin
               wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
               ra_in = wp_ff;
               fill_in = fill_nx;
               n_in = (fill_nx < winc) ? fill_nx : winc;
               k_in = '0; se_in = '0; sn_in = '0;
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            // read data valid next cycle; start CORDIC then
            trig_go_in = 1'b1;
            state_in = S_TRIG;
         end
         S_TRIG: begin
            if (trig_done) begin
               se_in = se_ff + SumWidth'(east);
               sn_in = sn_ff + SumWidth'(north);
               k_in = k_ff + 1'b1;
               ra_in = (ra_ff == '0) ? AW'(DEPTH-1) : ra_ff - 1'b1;
               if (k_ff + 1'b1 == n_ff) begin
                  state_in = S_BEAR;
                  bear_go_in = 1'b1;
               end else state_in = S_RDA;
            end
         end
         S_BEAR: begin
            if (bear_done) begin
               mean_in = bmean;
               ra_in = (wp_ff == '0) ? AW'(DEPTH-1) : wp_ff - 1'b1;
               k_in = '0;
               port_in = (DirWidth+1)'(FullTurn);
               stb_in = -(DirWidth+1)'(FullTurn);
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            if (rdv_ff) begin
               if (dvw < port_ff) port_in = dvw;
               if (dvw > stb_ff) stb_in = dvw;
            end
            if (k_ff == n_ff) begin
               state_in = S_LAST;
            end else begin
               ra_in = (ra_ff == '0) ? AW'(DEPTH-1) : ra_ff - 1'b1;
               k_in = k_ff + 1'b1;
               rdv_in = 1'b1;
            end
         end
         S_LAST: begin
            if (rdv_ff) begin
               if (dvw < port_ff) port_in = dvw;
               if (dvw > stb_ff) stb_in = dvw;
            end
            if (!rdv_ff) state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_v_ff) begin
               out_in = {DirWidth'(n_ff), stb_ff[11:0], port_ff[11:0], mean_ff};
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ra_ff <= ra_in; n_ff <= n_in; k_ff <= k_in; se_ff <= se_in; sn_ff <= sn_in;
      port_ff <= port_in; stb_ff <= stb_in; mean_ff <= mean_in; out_ff <= out_in;
      if (reset) begin
         state_ff <= S_IDLE; wp_ff <= '0; fill_ff <= '0; win_ff <= 12'd360;
         rdv_ff <= 1'b0; trig_go_ff <= 1'b0; bear_go_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; wp_ff <= wp_in; fill_ff <= fill_in;
         rdv_ff <= rdv_in; trig_go_ff <= trig_go_in; bear_go_ff <= bear_go_in;
         out_v_ff <= out_v_in;
         if (csr_valid && csr_ready) win_ff <= csr_data[11:0];
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH)) else $error("fill count above depth");
   a_used_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[47:36] != 12'd0)) else $error("zero samples used");
   a_mean_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:0] < 12'd3600)) else $error("mean out of range");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
`endif
endmodule

// ===== rtl/wcmd_sincos.sv =====
// Iterative CORDIC rotation: compass east/north parts of one direction.
module wcmd_sincos (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  wcmd_pkg::dir_type      dir,
   output logic                   done,
   output wcmd_pkg::trig_type     east,
   output wcmd_pkg::trig_type     north
);
   import wcmd_pkg::*;

   logic signed [RotWidth-1:0] x_ff, x_in, y_ff, y_in;
   ang_type z_ff, z_in;
   logic [1:0] q_ff, q_in;
   logic [StepBits-1:0] i_ff, i_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DirWidth-1:0] rem;
   logic [1:0] quad;
   trig_type s, c;

   always_comb begin
      if (dir >= DirWidth'(3*QuarterTurn)) begin
         quad = 2'd3; rem = dir - DirWidth'(3*QuarterTurn);
      end else if (dir >= DirWidth'(2*QuarterTurn)) begin
         quad = 2'd2; rem = dir - DirWidth'(2*QuarterTurn);
      end else if (dir >= DirWidth'(QuarterTurn)) begin
         quad = 2'd1; rem = dir - DirWidth'(QuarterTurn);
      end else begin
         quad = 2'd0; rem = dir;
      end
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; q_in = q_ff;
      i_in = i_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         x_in = CordStart; y_in = '0;
         z_in = AngWidth'(rem) * AngWidth'(1000);
         q_in = quad; i_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[AngWidth-1]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - atan_units(i_ff);
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + atan_units(i_ff);
         end
         i_in = i_ff + 1'b1;
         if (i_ff == StepBits'(CordSteps-1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; q_ff <= q_in; i_ff <= i_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign s = to_q15(y_ff);
   assign c = to_q15(x_ff);
   assign done = done_ff;

   always_comb begin
      case (q_ff)
         2'd0: begin east = s;  north = c;  end
         2'd1: begin east = c;  north = -s; end
         2'd2: begin east = -s; north = -c; end
         default: begin east = -c; north = s; end
      endcase
   end
endmodule

// ===== rtl/wcmd_bearing.sv =====
// Iterative CORDIC vectoring: bearing of summed vector in tenths.
module wcmd_bearing (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  wcmd_pkg::sum_type      sum_e,
   input  wcmd_pkg::sum_type      sum_n,
   output logic                   done,
   output wcmd_pkg::dir_type      mean
);
   import wcmd_pkg::*;

   logic signed [VecWidth-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   ang_type z_ff, z_in;
   logic [StepBits-1:0] i_ff, i_in;
   logic busy_ff, busy_in, fin_ff, fin_in, zero_ff, zero_in;
   logic [1:0] div_ff, div_in;   // 1 divide, 2 result
   logic signed [AngWidth-1:0] tot_ff, tot_in;
   logic [DirWidth:0] quo_ff, quo_in;
   dir_type mean_ff, mean_in;
   logic done_ff, done_in;

   assign xs = VecWidth'(sum_n) <<< 16;
   assign ys = VecWidth'(sum_e) <<< 16;

   // total lies in 2601688..6399312; divide by 1000 by stepping 1000*2^k
   logic signed [AngWidth-1:0] sub;
   assign sub = AngWidth'(1000) <<< i_ff;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; fin_in = 1'b0; zero_in = zero_ff;
      div_in = 2'd0; tot_in = tot_ff; quo_in = quo_ff;
      mean_in = mean_ff; done_in = 1'b0;
      if (start) begin
         zero_in = (sum_e == '0) && (sum_n == '0);
         if (xs[VecWidth-1]) begin
            x_in = -xs; y_in = -ys; z_in = AngWidth'(HalfTurn*1000);
         end else begin
            x_in = xs; y_in = ys; z_in = '0;
         end
         i_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!y_ff[VecWidth-1] && (y_ff != '0)) begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + atan_units(i_ff);
         end else begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - atan_units(i_ff);
         end
         i_in = i_ff + 1'b1;
         if (i_ff == StepBits'(CordSteps-1)) begin
            busy_in = 1'b0; fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         tot_in = z_ff + AngWidth'(FullTurn*1000 + 500);
         quo_in = '0; i_in = StepBits'(12); div_in = 2'd1;
      end else if (div_ff == 2'd1) begin
         if (tot_ff >= sub) begin
            tot_in = tot_ff - sub;
            quo_in = quo_ff | ((DirWidth+1)'(1) << i_ff);
         end
         i_in = i_ff - 1'b1;
         if (i_ff == '0) div_in = 2'd2;
         else div_in = 2'd1;
      end else if (div_ff == 2'd2) begin
         if (zero_ff) mean_in = DirWidth'(QuarterTurn);
         else if (quo_ff >= (DirWidth+1)'(FullTurn))
            mean_in = DirWidth'(quo_ff - (DirWidth+1)'(FullTurn));
         else mean_in = quo_ff[DirWidth-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      tot_ff <= tot_in; quo_ff <= quo_in; mean_ff <= mean_in; zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0; fin_ff <= 1'b0; div_ff <= 2'd0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; fin_ff <= fin_in; div_ff <= div_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign mean = mean_ff;
endmodule

// ===== sim/windowed_circular_mean_direction_unit_tb.sv =====
module windowed_circular_mean_direction_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wcmd_pkg::*;

   localparam int Depth = 2048;

   // one expected result
   typedef struct packed {
      logic [11:0] samples_used;
      logic [11:0] starboard_range;
      logic [11:0] port_range;
      logic [11:0] mean_direction;
   } mean_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   windowed_circular_mean_direction_unit #(.DEPTH(Depth)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // predictor state: own copy of the history, pointer, fill level and window
   dir_type      hist_mem [Depth];
   int unsigned  hist_wp;
   int unsigned  hist_fill;
   int unsigned  window_reg;

   mean_result_type mean_due [$];
   int           mismatches;
   int           items_sent;
   int           results_seen;
   bit           quiet;          // no idling in the closing stretch
   int           widest_window;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

   // --- predictor -------------------------------------------------------

   function automatic longint q15_round(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   // compass east/north components of a bearing in tenths, Q1.15
   function automatic void compass_parts(input int unsigned d,
                                         output longint east, output longint north);
      longint x, y, z, dx, dy, s, c;
      x = longint'(CordStart);
      y = 0;
      z = longint'(d % QuarterTurn) * 1000;
      for (int i = 0; i < CordSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_units(i[3:0]));
         end else begin
            x += dx; y -= dy; z += longint'(atan_units(i[3:0]));
         end
      end
      s = q15_round(y);
      c = q15_round(x);
      case ((d / QuarterTurn) % 4)
         0: begin east = s;  north = c;  end
         1: begin east = c;  north = -s; end
         2: begin east = -s; north = -c; end
         default: begin east = -c; north = s; end
      endcase
   endfunction

   // bearing of the summed vector, 0..3599; zero vector gives due east
   function automatic int unsigned vector_bearing(input longint east, input longint north);
      longint x, y, z, dx, dy, total;
      if (east == 0 && north == 0) return QuarterTurn;
      x = north * 65536;
      y = east * 65536;
      z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = longint'(HalfTurn) * 1000;
      end
      for (int i = 0; i < CordSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_units(i[3:0]));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_units(i[3:0]));
         end
      end
      total = z + longint'(FullTurn) * 1000 + 500;
      return int'((total / 1000) % FullTurn);
   endfunction

   function automatic mean_result_type predict_mean(input logic [11:0] raw_dir);
      mean_result_type r;
      int unsigned  d, win, used, idx, mean;
      longint       sum_e, sum_n, e, n;
      int           dev, port, stb;
      d = int'(raw_dir) % FullTurn;
      hist_mem[hist_wp] = dir_type'(d);
      hist_wp = (hist_wp + 1) % Depth;
      if (hist_fill < Depth) hist_fill++;
      win = window_reg;
      if (win < 1) win = 1;
      if (win > Depth) win = Depth;
      used = (hist_fill < win) ? hist_fill : win;
      sum_e = 0;
      sum_n = 0;
      for (int k = 0; k < used; k++) begin
         idx = (hist_wp + Depth - 1 - k) % Depth;
         compass_parts(hist_mem[idx], e, n);
         sum_e += e;
         sum_n += n;
      end
      mean = vector_bearing(sum_e, sum_n);
      port = FullTurn;
      stb  = -FullTurn;
      for (int k = 0; k < used; k++) begin
         idx = (hist_wp + Depth - 1 - k) % Depth;
         dev = int'(hist_mem[idx]) - int'(mean);
         if (dev > HalfTurn) dev -= FullTurn;
         if (dev < -HalfTurn) dev += FullTurn;
         if (dev < port) port = dev;
         if (dev > stb) stb = dev;
      end
      if (used > widest_window) widest_window = used;
      r.mean_direction  = mean[11:0];
      r.port_range      = port[11:0];
      r.starboard_range = stb[11:0];
      r.samples_used    = used[11:0];
      return r;
   endfunction

   // --- checking --------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %0s: got %0d, expected %0d (result %0d)",
               what, got, want, results_seen);
      mismatches++;
   endtask

   always @(posedge clock) begin
      mean_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (mean_due.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = mean_due.pop_front();
            if (got.mean_direction !== want.mean_direction)
               report_mismatch("mean_direction", got.mean_direction, want.mean_direction);
            if (got.port_range !== want.port_range)
               report_mismatch("port_range", $signed(got.port_range),
                               $signed(want.port_range));
            if (got.starboard_range !== want.starboard_range)
               report_mismatch("starboard_range", $signed(got.starboard_range),
                               $signed(want.starboard_range));
            if (got.samples_used !== want.samples_used)
               report_mismatch("samples_used", got.samples_used, want.samples_used);
         end
         results_seen++;
      end
   end

   // receiver stalls in bursts, none once quiet
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_tready && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         rsp_tready <= 1'b1;
      end
   end

   // --- driving ---------------------------------------------------------

   // one direction item, with an optional idle burst ahead of it;
   // valid stays up on return so back-to-back calls drive it only once per edge
   task automatic send_direction(input logic [11:0] dir);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, dir};
      do @(posedge clock); while (!req_tready);
      mean_due.push_back(predict_mean(dir));
      items_sent++;
      @(negedge clock);
   endtask

   // sender holds off until every expected result is in
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (mean_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window(input int unsigned len);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= {4'b0, len[11:0]};
      do @(posedge clock); while (!csr_ready);
      window_reg = len & 12'hfff;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // --- tests -----------------------------------------------------------

   // reset window of 360, field extremes, quadrant edges, out-of-range input
   task automatic test_directed_directions;
      logic [11:0] dirs [] = '{12'd0, 12'd3599, 12'd900, 12'd899, 12'd901, 12'd1800,
                                12'd2700, 12'd3600, 12'd4095, 12'd1, 12'd1799,
                                12'd2699, 12'd3000};
      foreach (dirs[i]) send_direction(dirs[i]);
   endtask

   // window 0 acts as 1; opposite pair gives the zero vector; oversize clamps
   task automatic test_window_extremes;
      write_window(0);
      send_direction(12'd1234);
      send_direction(12'd4000);
      write_window(1);
      send_direction(12'd2345);
      write_window(2);
      send_direction(12'd0);
      send_direction(12'd1800);
      send_direction(12'd900);
      send_direction(12'd2700);
      write_window(2048);
      send_direction(12'd100);
      send_direction(12'd3500);
      write_window(4095);
      send_direction(12'd1790);
      send_direction(12'd1810);
   endtask

   // random directions under a run of window settings, with one drain pause
   task automatic test_random_directions;
      int unsigned windows [] = '{3, 17, 1, 360, 8, 2048, 5, 4095};
      int unsigned base;
      for (int p = 0; p < windows.size(); p++) begin
         write_window(windows[p]);
         base = $urandom_range(0, 3599);
         for (int k = 0; k < 15; k++) begin
            if (p == windows.size() - 1 && k == 8) quiet = 1'b1;
            if (p == 2 && k == 7) wait_drained();
            // mostly clustered around a heading, now and then anything
            if ($urandom_range(0, 3) == 0)
               send_direction(12'($urandom_range(0, 4095)));
            else
               send_direction(12'((base + 3600 + $urandom_range(0, 600) - 300) % 3600));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      quiet      = 1'b0;
      mismatches = 0;
      items_sent = 0;
      results_seen = 0;
      widest_window = 0;
      hist_wp    = 0;
      hist_fill  = 0;
      window_reg = 360;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_directed_directions();
      test_window_extremes();
      test_random_directions();

      wait_drained();
      repeat (100) @(negedge clock);
      $display("covered %0d direction items, %0d results, up to %0d samples per mean",
               items_sent, results_seen, widest_window);
      $display("windows 0, 1, 2, small, 360, 2048 and 4095; zero vector and wrap cases");
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
